// ===== src/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression is never true on a rising edge of clk.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== src/udf_pkg.sv =====
// Types and constants of the UDP destination frame filter.
`default_nettype none

package udf_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_UDP_PORT = 1'b1;

  localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RESET = 32'hE000_0064;
  localparam logic [PORT_W-1:0] TARGET_UDP_PORT_RESET = 16'd40000;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [3:0] IHL_MASK = 4'hF;
  localparam logic [LEN_W-1:0] ETH_HEADER = 16'd14;
  localparam logic [LEN_W-1:0] MIN_FRAME = 16'd42;
  localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;
  localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

  localparam logic [LEN_W-1:0] POS_ETYPE_HI = 16'd12;
  localparam logic [LEN_W-1:0] POS_ETYPE_LO = 16'd13;
  localparam logic [LEN_W-1:0] POS_PROTOCOL = 16'd23;
  localparam logic [LEN_W-1:0] POS_DEST_FIRST = 16'd30;
  localparam logic [LEN_W-1:0] POS_DEST_LAST = 16'd33;

  localparam logic [2:0] VERDICT_MATCH = 3'd0;
  localparam logic [2:0] VERDICT_SHORT = 3'd1;
  localparam logic [2:0] VERDICT_NOT_IPV4 = 3'd2;
  localparam logic [2:0] VERDICT_BAD_IHL = 3'd3;
  localparam logic [2:0] VERDICT_NOT_UDP = 3'd4;
  localparam logic [2:0] VERDICT_WRONG_ADDR = 3'd5;
  localparam logic [2:0] VERDICT_WRONG_PORT = 3'd6;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_req_t;

  typedef struct packed {
    logic [2:0]       verdict;
    logic [LEN_W-1:0] frame_length;
    logic [CNT_W-1:0] frames_seen;
    logic [CNT_W-1:0] frames_matched;
  } frame_result_t;

endpackage

`default_nettype wire

// ===== src/udp_destination_frame_filter.sv =====
// Top level of the UDP destination frame filter.
// A frame byte taken into the input register is judged by the capture and compare
// stage; the final byte of a frame loads its result into the result register.
// Throughput: one byte per cycle while no final byte waits, set by the single
// capture and compare stage between input and result register. The final byte of a
// frame waits only while the result register still holds an unread result.
// Synchronous reset clears the pipeline, counters and frame state.
`default_nettype none
`include "assert_macros.svh"

module udp_destination_frame_filter import udf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   frame_valid,
  output logic                        frame_stall,
  input  wire frame_req_t             frame,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output frame_result_t               result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ADDR_W-1:0] target_address;
  logic [PORT_W-1:0] target_udp_port;

  logic       s1_valid;
  frame_req_t s1;

  logic [LEN_W-1:0]  byte_position, byte_position_next;
  logic [15:0]       ether_kind, ether_kind_next;
  logic [5:0]        header_bytes, header_bytes_next;
  logic [7:0]        ip_protocol, ip_protocol_next;
  logic [ADDR_W-1:0] destination_seen, destination_seen_next;
  logic [PORT_W-1:0] port_seen, port_seen_next;
  logic [CNT_W-1:0]  total_count, total_count_next;
  logic [CNT_W-1:0]  match_count, match_count_next;

  logic             out_free;
  logic             s1_consume;
  logic             s1_done;
  logic             frame_take;
  logic [LEN_W-1:0] port_at;
  logic [LEN_W-1:0] frame_len;
  logic [2:0]       verdict_calc;

  assign out_free = !result_valid || !result_stall;
  assign s1_consume = s1_valid && (!s1.frame_end || out_free);
  assign s1_done = s1_consume && s1.frame_end;
  assign frame_stall = s1_valid && !s1_consume;
  assign frame_take = frame_valid && !frame_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= TARGET_ADDRESS_RESET;
      target_udp_port <= TARGET_UDP_PORT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_ADDRESS:  target_address <= cfg_data[ADDR_W-1:0];
        CFG_TARGET_UDP_PORT: target_udp_port <= cfg_data[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_take) begin
      s1_valid <= 1'b1;
    end else if (s1_consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      s1 <= frame;
    end
  end

  // capture and judge
  always_comb begin
    port_at = ETH_HEADER + 16'd2 + {10'd0, header_bytes};
    frame_len = (byte_position < LEN_MAX) ? byte_position + 16'd1 : LEN_MAX;

    ether_kind_next = ether_kind;
    header_bytes_next = header_bytes;
    ip_protocol_next = ip_protocol;
    destination_seen_next = destination_seen;
    port_seen_next = port_seen;

    if (byte_position == POS_ETYPE_HI || byte_position == POS_ETYPE_LO) begin
      ether_kind_next = {ether_kind[7:0], s1.frame_byte};
    end
    if (byte_position == ETH_HEADER) begin
      header_bytes_next = {s1.frame_byte[3:0] & IHL_MASK, 2'b00};
    end
    if (byte_position == POS_PROTOCOL) begin
      ip_protocol_next = s1.frame_byte;
    end
    if (byte_position >= POS_DEST_FIRST && byte_position <= POS_DEST_LAST) begin
      destination_seen_next = {destination_seen[ADDR_W-9:0], s1.frame_byte};
    end
    if (byte_position > ETH_HEADER &&
        (byte_position == port_at || byte_position == port_at + 16'd1)) begin
      port_seen_next = {port_seen[7:0], s1.frame_byte};
    end

    if (frame_len < MIN_FRAME) begin
      verdict_calc = VERDICT_SHORT;
    end else if (ether_kind_next != ETHERTYPE_IPV4) begin
      verdict_calc = VERDICT_NOT_IPV4;
    end else if (header_bytes_next < MIN_HEADER_BYTES) begin
      verdict_calc = VERDICT_BAD_IHL;
    end else if (ip_protocol_next != PROTO_UDP) begin
      verdict_calc = VERDICT_NOT_UDP;
    end else if (destination_seen_next != target_address) begin
      verdict_calc = VERDICT_WRONG_ADDR;
    end else if (frame_len < ETH_HEADER + 16'd4 + {10'd0, header_bytes_next}) begin
      verdict_calc = VERDICT_SHORT;
    end else if (port_seen_next != target_udp_port) begin
      verdict_calc = VERDICT_WRONG_PORT;
    end else begin
      verdict_calc = VERDICT_MATCH;
    end

    total_count_next = total_count + 32'd1;
    match_count_next = (verdict_calc == VERDICT_MATCH) ? match_count + 32'd1 : match_count;
    byte_position_next = s1.frame_end ? '0 : frame_len;
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_kind <= '0;
      header_bytes <= '0;
      ip_protocol <= '0;
      destination_seen <= '0;
      port_seen <= '0;
      total_count <= '0;
      match_count <= '0;
    end else if (s1_consume) begin
      byte_position <= byte_position_next;
      if (s1.frame_end) begin
        ether_kind <= '0;
        header_bytes <= '0;
        ip_protocol <= '0;
        destination_seen <= '0;
        port_seen <= '0;
        total_count <= total_count_next;
        match_count <= match_count_next;
      end else begin
        ether_kind <= ether_kind_next;
        header_bytes <= header_bytes_next;
        ip_protocol <= ip_protocol_next;
        destination_seen <= destination_seen_next;
        port_seen <= port_seen_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      result.verdict <= verdict_calc;
      result.frame_length <= frame_len;
      result.frames_seen <= total_count_next;
      result.frames_matched <= match_count_next;
    end
  end

  `ASSERT_CLKD(a_seen_count,
    s1_done |=> result_valid && result.frames_seen == $past(total_count) + 32'd1,
    "frames_seen does not follow the frame count")
  `ASSERT_CLKD(a_pos_clear, s1_done |=> byte_position == '0,
    "byte position not cleared after frame end")
  `ASSERT_CLKD(a_match_hold,
    s1_done && verdict_calc != VERDICT_MATCH |=> match_count == $past(match_count),
    "match count moved on a rejected frame")
  `ASSERT_NEVER(a_stall_cause,
    frame_stall && !(s1_valid && s1.frame_end && result_valid && result_stall),
    "request stalled without a blocked result")

endmodule

`default_nettype wire
